@@ src/ptc_pkg.sv @@
package ptc_pkg;

   // input beat: one raw reading pair
   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
   } req_type;

   // result beat
   typedef struct packed {
      logic signed [31:0] temperature;
      logic signed [31:0] fine_temperature;
      logic [31:0]        pressure;
      logic               pressure_valid;
   } rsp_type;

   // register index, taken from address bits 4:3
   typedef enum logic [1:0] {
      CSR_TEMP_CALIB    = 2'd0,
      CSR_PRESS_CALIB_A = 2'd1,
      CSR_PRESS_CALIB_B = 2'd2,
      CSR_PRESS_CALIB_P9 = 2'd3
   } csr_idx_type;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   // compensation constants
   localparam logic signed [32:0] T_FINE_OFFSET = 33'sd128000;
   localparam logic [20:0]        P_FULL_SCALE  = 21'd1048576;
   localparam logic [63:0]        P_SCALE       = 64'd3125;
   localparam logic signed [31:0] T_ROUND       = 32'sd128;
   localparam logic signed [31:0] T_MULT        = 32'sd5;
   localparam logic [63:0]        VAR1_BIAS     = 64'h0000_8000_0000_0000;

   // restoring divider: one quotient bit per stage
   localparam int DIV_STEPS = 64;
   localparam int DEN_W     = 31;

   typedef struct packed {
      logic               v;
      logic [63:0]        num;   // dividend, becomes quotient
      logic [DEN_W-1:0]   rem;
      logic [DEN_W-1:0]   den;
      logic               neg;
      logic signed [31:0] temp;
      logic signed [31:0] tfine;
      logic               pvalid;
   } div_stage_type;

endpackage

@@ src/ptc_div.sv @@
module ptc_div
   import ptc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  div_stage_type div_in,
   output div_stage_type div_out
);

   div_stage_type    stage_ff [0:DIV_STEPS];
   div_stage_type    stage_in [0:DIV_STEPS-1];
   logic [DEN_W:0]   rem_sh   [0:DIV_STEPS-1];
   logic             ge       [0:DIV_STEPS-1];

   always_comb begin
      for (int i = 0; i < DIV_STEPS; i++) begin
         rem_sh[i]   = {stage_ff[i].rem, stage_ff[i].num[63]};
         ge[i]       = rem_sh[i] >= {1'b0, stage_ff[i].den};
         stage_in[i] = stage_ff[i];
         stage_in[i].num = {stage_ff[i].num[62:0], ge[i]};
         if (ge[i]) begin
            stage_in[i].rem = DEN_W'(rem_sh[i] - {1'b0, stage_ff[i].den});
         end else begin
            stage_in[i].rem = rem_sh[i][DEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DIV_STEPS; i++) stage_ff[i].v <= 1'b0;
      end else if (en) begin
         stage_ff[0] <= div_in;
         for (int i = 0; i < DIV_STEPS; i++) stage_ff[i+1] <= stage_in[i];
      end
   end

   assign div_out = stage_ff[DIV_STEPS];

endmodule

@@ src/pressure_temp_compensation.sv @@
// Pressure / temperature compensation, integer form with a 64-bit pressure path.
//
// Channels:
//   req_*  : one beat = raw temperature and raw pressure (20 bits each).
//   rsp_*  : one beat = temperature (0.01 degC), fine temperature,
//            pressure (Pa, unsigned Q24.8) and a pressure valid flag.
//   csr    : APB-style, 64-bit data; calibration words at 0x00, 0x08, 0x10,
//            0x18 (address bits 4:3 pick the register). Write only while idle.
// Pipeline: 10 front stages (temperature, then 64-bit pressure terms built
//   from 32x32-class multiplies), 65 stages of the restoring divider (an
//   input stage, then one quotient bit per stage), 6 back stages, then the
//   output register.
// Throughput: one beat per cycle while not stalled, set by the fully pipelined divider.
// Stall: the pipeline moves as one. When rsp is held off, the beat leaving
//   the pipeline drops into a one-entry skid register and req_ready falls
//   the next cycle; nothing is lost or repeated.
// Reset: clears all valid bits, the skid and the calibration registers.
// A zero divisor gives pressure 0 and pressure_valid 0.
module pressure_temp_compensation
   import ptc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // ---------------- calibration registers ----------------
   logic [47:0] temp_calib_ff;
   logic [63:0] press_a_ff;
   logic [63:0] press_b_ff;
   logic [15:0] press_p9_ff;
   csr_idx_type csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = csr_idx_type'(paddr[4:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff <= '0;
         press_a_ff    <= '0;
         press_b_ff    <= '0;
         press_p9_ff   <= '0;
      end else if (psel && penable && pwrite) begin
         case (csr_idx)
            CSR_TEMP_CALIB:     temp_calib_ff <= pwdata[47:0];
            CSR_PRESS_CALIB_A:  press_a_ff    <= pwdata;
            CSR_PRESS_CALIB_B:  press_b_ff    <= pwdata;
            CSR_PRESS_CALIB_P9: press_p9_ff   <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_TEMP_CALIB:     prdata = {16'b0, temp_calib_ff};
         CSR_PRESS_CALIB_A:  prdata = press_a_ff;
         CSR_PRESS_CALIB_B:  prdata = press_b_ff;
         CSR_PRESS_CALIB_P9: prdata = {48'b0, press_p9_ff};
         default:            prdata = '0;
      endcase
   end

   // coefficient fields; the user must keep them static while items are in flight (not enforced here)
   logic [15:0]        t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = temp_calib_ff[15:0];
   assign t2 = temp_calib_ff[31:16];
   assign t3 = temp_calib_ff[47:32];
   assign p1 = press_a_ff[15:0];
   assign p2 = press_a_ff[31:16];
   assign p3 = press_a_ff[47:32];
   assign p4 = press_a_ff[63:48];
   assign p5 = press_b_ff[15:0];
   assign p6 = press_b_ff[31:16];
   assign p7 = press_b_ff[47:32];
   assign p8 = press_b_ff[63:48];
   assign p9 = press_p9_ff;

   // ---------------- flow control ----------------
   logic    en;
   logic    skid_v_ff;
   rsp_type skid_ff;
   logic    out_v_ff;
   rsp_type out_ff;
   assign en        = !skid_v_ff;
   assign req_ready = en;

   logic [9:0] fv_ff;   // front stage valids
   logic [5:0] bv_ff;   // back stage valids

   // ---------------- front stages ----------------
   // s1: first temperature products
   logic signed [17:0] da_in, d_in;
   logic signed [33:0] a_full;
   logic signed [35:0] dd_full;
   logic signed [31:0] a_ff, dd_ff;
   logic [19:0]        rawp1_ff;
   always_comb begin
      da_in   = $signed({1'b0, req_data.raw_temperature[19:3]})
              - $signed({1'b0, t1, 1'b0});
      d_in    = $signed({2'b0, req_data.raw_temperature[19:4]})
              - $signed({2'b0, t1});
      a_full  = da_in * t2;
      dd_full = d_in * d_in;
   end

   // s2
   logic signed [47:0] m_full;
   logic signed [31:0] ddsh_in;
   logic signed [31:0] v1_ff, m_ff;
   logic [19:0]        rawp2_ff;
   always_comb begin
      ddsh_in = dd_ff >>> 12;
      m_full  = ddsh_in * t3;
   end

   // s3
   logic signed [31:0] tfine_in, tfine3_ff;
   logic [19:0]        rawp3_ff;
   assign tfine_in = v1_ff + (m_ff >>> 14);

   // s4: temperature out, pressure path start
   logic signed [31:0] t5_in, temp_in;
   logic signed [32:0] w1_in, w1_ff;
   logic signed [31:0] temp4_ff, tfine4_ff;
   logic [19:0]        rawp4_ff;
   always_comb begin
      t5_in   = 32'(tfine3_ff * T_MULT) + T_ROUND;
      temp_in = t5_in >>> 8;
      w1_in   = 33'(tfine3_ff) - T_FINE_OFFSET;
   end

   // s5: square and first coefficient products
   logic signed [65:0] sq_full;
   logic signed [63:0] sq_ff;
   logic signed [48:0] wp5_ff, wp2_ff;
   logic signed [31:0] temp5_ff, tfine5_ff;
   logic [19:0]        rawp5_ff;
   assign sq_full = w1_ff * w1_ff;

   // s6
   logic signed [79:0] t6_full, t3_full;
   logic signed [63:0] t6_ff, t3p_ff;
   logic signed [48:0] wp5b_ff, wp2b_ff;
   logic signed [31:0] temp6_ff, tfine6_ff;
   logic [19:0]        rawp6_ff;
   always_comb begin
      t6_full = sq_ff * p6;
      t3_full = sq_ff * p3;
   end

   // s7: var2 and var1 sums
   logic signed [63:0] wp5x, wp2x, p4x, w2_in, var1_in;
   logic signed [63:0] w2_ff, var1_ff;
   logic signed [31:0] temp7_ff, tfine7_ff;
   logic [19:0]        rawp7_ff;
   always_comb begin
      wp5x    = 64'(wp5b_ff);
      wp2x    = 64'(wp2b_ff);
      p4x     = 64'(p4);
      w2_in   = t6_ff + (wp5x <<< 17) + (p4x <<< 35);
      var1_in = (t3p_ff >>> 8) + (wp2x <<< 12);
   end

   // s8: divisor product, numerator difference
   logic [63:0]        xa_in;
   logic [79:0]        x_full;
   logic [20:0]        pd_in;
   logic [63:0]        x_ff, nd_ff;
   logic signed [31:0] temp8_ff, tfine8_ff;
   always_comb begin
      xa_in  = VAR1_BIAS + var1_ff;
      x_full = xa_in * p1;
      pd_in  = P_FULL_SCALE - {1'b0, rawp7_ff};
   end

   // s9: scaled numerator, divisor
   logic [63:0]        num_ff;
   logic [DEN_W-1:0]   dv_ff;
   logic               pv9_ff;
   logic signed [31:0] temp9_ff, tfine9_ff;

   // s10: magnitudes for the divider
   logic [63:0]        an_ff;
   logic [DEN_W-1:0]   ad_ff;
   logic               neg_ff, pv10_ff;
   logic signed [31:0] temp10_ff, tfine10_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff       <= a_full[31:0];
         dd_ff      <= dd_full[31:0];
         rawp1_ff   <= req_data.raw_pressure;
         v1_ff      <= a_ff >>> 11;
         m_ff       <= m_full[31:0];
         rawp2_ff   <= rawp1_ff;
         tfine3_ff  <= tfine_in;
         rawp3_ff   <= rawp2_ff;
         temp4_ff   <= temp_in;
         tfine4_ff  <= tfine3_ff;
         w1_ff      <= w1_in;
         rawp4_ff   <= rawp3_ff;
         sq_ff      <= sq_full[63:0];
         wp5_ff     <= w1_ff * p5;
         wp2_ff     <= w1_ff * p2;
         temp5_ff   <= temp4_ff;
         tfine5_ff  <= tfine4_ff;
         rawp5_ff   <= rawp4_ff;
         t6_ff      <= t6_full[63:0];
         t3p_ff     <= t3_full[63:0];
         wp5b_ff    <= wp5_ff;
         wp2b_ff    <= wp2_ff;
         temp6_ff   <= temp5_ff;
         tfine6_ff  <= tfine5_ff;
         rawp6_ff   <= rawp5_ff;
         w2_ff      <= w2_in;
         var1_ff    <= var1_in;
         temp7_ff   <= temp6_ff;
         tfine7_ff  <= tfine6_ff;
         rawp7_ff   <= rawp6_ff;
         x_ff       <= x_full[63:0];
         nd_ff      <= {12'b0, pd_in, 31'b0} - w2_ff;
         temp8_ff   <= temp7_ff;
         tfine8_ff  <= tfine7_ff;
         num_ff     <= 64'(nd_ff * P_SCALE);
         dv_ff      <= x_ff[63:33];
         pv9_ff     <= |x_ff[63:33];
         temp9_ff   <= temp8_ff;
         tfine9_ff  <= tfine8_ff;
         an_ff      <= num_ff[63] ? 64'(0 - num_ff) : num_ff;
         ad_ff      <= dv_ff[DEN_W-1] ? DEN_W'(0 - dv_ff) : dv_ff;
         neg_ff     <= num_ff[63] ^ dv_ff[DEN_W-1];
         pv10_ff    <= pv9_ff;
         temp10_ff  <= temp9_ff;
         tfine10_ff <= tfine9_ff;
      end
   end

   // ---------------- divider ----------------
   div_stage_type div_in, div_out;
   always_comb begin
      div_in        = '0;
      div_in.v      = fv_ff[9];
      div_in.num    = an_ff;
      div_in.den    = ad_ff;
      div_in.neg    = neg_ff;
      div_in.temp   = temp10_ff;
      div_in.tfine  = tfine10_ff;
      div_in.pvalid = pv10_ff;
   end

   ptc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .div_in  (div_in),
      .div_out (div_out)
   );

   // ---------------- back stages ----------------
   logic signed [63:0] pq_ff;                       // b1: signed quotient
   logic signed [63:0] s_in;
   logic signed [79:0] ps_full, x2_full;
   logic signed [63:0] ps_ff, s_ff, x2m_ff, pq2_ff; // b2
   logic [63:0]        ll_ff;                       // b3
   logic [31:0]        hl_ff, lh_ff;
   logic signed [63:0] x2m3_ff, pq3_ff;
   logic signed [63:0] pp_ff, x2_ff, pq4_ff;        // b4
   logic signed [63:0] sum_ff;                      // b5
   logic [31:0]        res_ff;                      // b6
   logic signed [63:0] p7x, res_in;
   logic signed [31:0] tempb_ff [0:5];
   logic signed [31:0] tfineb_ff [0:5];
   logic               pvb_ff [0:5];

   always_comb begin
      s_in    = pq_ff >>> 13;
      ps_full = s_in * p9;
      x2_full = pq_ff * p8;
      p7x     = 64'(p7);
      res_in  = (sum_ff >>> 8) + (p7x <<< 4);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pq_ff   <= div_out.neg ? 64'(0 - div_out.num) : div_out.num;
         ps_ff   <= ps_full[63:0];
         s_ff    <= s_in;
         x2m_ff  <= x2_full[63:0];
         pq2_ff  <= pq_ff;
         ll_ff   <= ps_ff[31:0] * s_ff[31:0];
         hl_ff   <= 32'(ps_ff[63:32] * s_ff[31:0]);
         lh_ff   <= 32'(ps_ff[31:0] * s_ff[63:32]);
         x2m3_ff <= x2m_ff;
         pq3_ff  <= pq2_ff;
         pp_ff   <= ll_ff + {32'(hl_ff + lh_ff), 32'b0};
         x2_ff   <= x2m3_ff >>> 19;
         pq4_ff  <= pq3_ff;
         sum_ff  <= pq4_ff + (pp_ff >>> 25) + x2_ff;
         res_ff  <= pvb_ff[4] ? res_in[31:0] : 32'd0;
         tempb_ff[0]  <= div_out.temp;
         tfineb_ff[0] <= div_out.tfine;
         pvb_ff[0]    <= div_out.pvalid;
         for (int i = 1; i < 6; i++) begin
            tempb_ff[i]  <= tempb_ff[i-1];
            tfineb_ff[i] <= tfineb_ff[i-1];
            pvb_ff[i]    <= pvb_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
         bv_ff <= '0;
      end else if (en) begin
         fv_ff <= {fv_ff[8:0], req_valid};
         bv_ff <= {bv_ff[4:0], div_out.v};
      end
   end

   // ---------------- output register and skid ----------------
   rsp_type last_in;
   logic    out_take;
   always_comb begin
      last_in.temperature      = tempb_ff[5];
      last_in.fine_temperature = tfineb_ff[5];
      last_in.pressure         = res_ff;
      last_in.pressure_valid   = pvb_ff[5];
      out_take                 = !out_v_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (en) begin
         if (out_take) begin
            out_v_ff <= bv_ff[5];
         end else if (bv_ff[5]) begin
            skid_v_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_v_ff  <= 1'b1;
         skid_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (out_take) begin
            out_ff <= last_in;
         end else begin
            skid_ff <= last_in;
         end
      end else if (out_take) begin
         out_ff <= skid_ff;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // ---------------- assertions ----------------
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid holds a beat while output is empty");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_ready))
      else $error("skid filled without an output stall");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.pressure_valid) |-> (rsp_data.pressure == 32'd0))
      else $error("pressure nonzero with zero divisor");

endmodule
